### hw/rtl/unifrac_distance_engine_unit_macros.svh
// Assertion macros for the UniFrac distance engine checker.
// No dependencies; the using module must have clk and rst_n in scope.
`ifndef UNIFRAC_DISTANCE_ENGINE_UNIT_MACROS_SVH
`define UNIFRAC_DISTANCE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define UFDE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define UFDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ufde_pkg.sv
// Shared constants and types of the UniFrac distance engine.
// No dependencies.
package ufde_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_OTUS    = 512;
    localparam int MAX_SAMPLES = 64;

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int OTU_W  = (MAX_OTUS > 1) ? $clog2(MAX_OTUS) : 1;
    localparam int SAMP_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // port field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 10;
    localparam int PARENT_W   = 11;
    localparam int LEN_W      = 32;
    localparam int COUNT_W    = 24;
    localparam int SAMPLE_W   = 6;
    localparam int DIST_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int OTU_CNT_W  = 10;
    localparam int EDGE_CNT_W = 11;

    // arithmetic widths
    localparam int FRAC_W     = 16;
    localparam int REL_W      = FRAC_W + 1;
    localparam int NORM_W     = 48;
    localparam int DEPTH_W    = COUNT_W + OTU_W + 1;
    localparam int SUM_W      = LEN_W + NODE_W;
    localparam int DEN_W      = NORM_W + 1;
    localparam int QUO_W      = SUM_W + FRAC_W;
    localparam int PROD_W     = LEN_W + REL_W;
    localparam int DIV_CNT_W  = $clog2(QUO_W);
    localparam int NODE_ENT_W = IDX_W + PARENT_W + LEN_W;
    localparam int WT_AW      = SAMP_W + NODE_W;

    localparam logic [OTU_CNT_W-1:0]  OTU_COUNT_RST  = OTU_CNT_W'(512);
    localparam logic [EDGE_CNT_W-1:0] EDGE_COUNT_RST = EDGE_CNT_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_NODE  = 2'd0,
        OP_LOAD_COUNT = 2'd1,
        OP_BUILD      = 2'd2,
        OP_PAIR       = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OTU_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 3'd3;

endpackage

### hw/rtl/ufde_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ufde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/unifrac_distance_engine_unit.sv
// UniFrac distance engine, top level. Uses ufde_pkg and five ufde_ram instances
// (node table, edge lengths, counts, edge-weight rows, sample norms).
//
// Usage: load tree nodes (op 0) and the current sample's OTU counts (op 1); the
// block stays ready after each. A build (op 2) clears the sample's row, sums the
// depth, then for every nonzero OTU divides for the relative abundance and walks
// toward the root, per edge a node read, weight read, multiply and write back
// when weighted. A pair op (op 3) sweeps the edges, reading the two samples'
// weights in turn since they share the one weight-row read port; a ratio result
// is then divided out, after reading both sample norms in weighted normalized mode.
// Only a pair op gives a result word; it sits in an output register so a new op
// is taken while it waits. Config writes are always ready and belong in idle time.
// Memories power up undefined and are never cleared by reset.
module unifrac_distance_engine_unit
    import ufde_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [OP_W-1:0]              op,
    input  logic [IDX_W-1:0]             node_index,
    input  logic [IDX_W-1:0]             edge_index,
    input  logic signed [PARENT_W-1:0]   parent_index,
    input  logic [LEN_W-1:0]             edge_length,
    input  logic [COUNT_W-1:0]           count,
    input  logic [SAMPLE_W-1:0]          sample_a,
    input  logic [SAMPLE_W-1:0]          sample_b,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [DIST_W-1:0]            distance,
    output logic                         status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_CLR   = 21'h000002,  // clear weight row
        S_DRD   = 21'h000004,  // depth: read count
        S_DACC  = 21'h000008,  // depth: accumulate
        S_ORD   = 21'h000010,  // OTU: read count
        S_OCHK  = 21'h000020,  // OTU: test count, start divide
        S_ODIV  = 21'h000040,  // OTU: wait for relative abundance
        S_WNODE = 21'h000080,  // walk: read node
        S_WEDGE = 21'h000100,  // walk: check edge, read weight
        S_WWT   = 21'h000200,  // walk: weight in hand
        S_WMUL  = 21'h000400,  // walk: weighted write back
        S_BFIN  = 21'h000800,  // build: store norm
        S_PA    = 21'h001000,  // pair: read weight a
        S_PB    = 21'h002000,  // pair: read weight b and length
        S_PC    = 21'h004000,  // pair: accumulate
        S_PFIN  = 21'h008000,
        S_PNA   = 21'h010000,
        S_PNB   = 21'h020000,
        S_PDEN  = 21'h040000,
        S_PDIV  = 21'h080000,
        S_POUT  = 21'h100000
    } state_t;

    // control
    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   div_busy_reg, div_busy_next;
    logic                   weighted_reg, weighted_next;
    logic                   normalize_reg, normalize_next;
    logic [OTU_CNT_W-1:0]   otu_count_reg, otu_count_next;
    logic [EDGE_CNT_W-1:0]  edge_count_reg, edge_count_next;

    // datapath
    logic [SAMP_W-1:0]      samp_a_reg, samp_a_next;
    logic [SAMP_W-1:0]      samp_b_reg, samp_b_next;
    logic [NODE_W:0]        e_reg, e_next;
    logic [OTU_W:0]         o_reg, o_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [NORM_W-1:0]      norm_reg, norm_next;
    logic [REL_W-1:0]       rel_reg, rel_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [NODE_W:0]        steps_reg, steps_next;
    logic [PARENT_W-1:0]    parent_reg, parent_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [NODE_W-1:0]      edge_reg, edge_next;
    logic [LEN_W-1:0]       w_reg, w_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SUM_W-1:0]       distinct_reg, distinct_next;
    logic [SUM_W-1:0]       shared_reg, shared_next;
    logic [LEN_W-1:0]       wa_reg, wa_next;
    logic [NORM_W-1:0]      na_reg, na_next;
    logic [DIST_W-1:0]      res_dist_reg, res_dist_next;
    logic                   res_stat_reg, res_stat_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic                   stat_reg, stat_next;

    // shared restoring divider
    logic [QUO_W-1:0]       div_num_reg, div_num_next;
    logic [DEN_W-1:0]       div_den_reg, div_den_next;
    logic [DEN_W-1:0]       div_rem_reg, div_rem_next;
    logic [QUO_W-1:0]       div_quo_reg, div_quo_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   div_start;
    logic [QUO_W-1:0]       div_num_in;
    logic [DEN_W-1:0]       div_den_in;
    logic [DEN_W:0]         div_rem_sh;
    logic [DEN_W:0]         div_diff;
    logic                   div_ge;

    // memory ports
    logic                   node_we;
    logic [NODE_W-1:0]      node_waddr, node_raddr;
    logic [NODE_ENT_W-1:0]  node_wdata, node_rdata;
    logic                   len_we;
    logic [NODE_W-1:0]      len_waddr, len_raddr;
    logic [LEN_W-1:0]       len_rdata;
    logic                   cnt_we;
    logic [OTU_W-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0]     cnt_rdata;
    logic                   wt_we;
    logic [WT_AW-1:0]       wt_waddr, wt_raddr;
    logic [LEN_W-1:0]       wt_wdata, wt_rdata;
    logic                   nrm_we;
    logic [SAMP_W-1:0]      nrm_waddr, nrm_raddr;
    logic [NORM_W-1:0]      nrm_rdata;

    logic                   in_accept;
    logic [NODE_W:0]        ne;
    logic [OTU_W:0]         no;
    logic [IDX_W-1:0]       f_edge;
    logic [PARENT_W-1:0]    f_parent;
    logic [LEN_W-1:0]       f_len;
    logic [LEN_W:0]         inc_raw;
    logic [LEN_W-1:0]       inc32;
    logic [LEN_W:0]         wt_sum;
    logic [NORM_W:0]        norm_sum;
    logic [LEN_W-1:0]       abs_diff;
    logic [DEN_W-1:0]       uw_den;
    logic [DEN_W-1:0]       nrm_den;
    logic                   walk_end;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign status    = stat_reg;

    // clamped register limits
    assign ne = (32'(edge_count_reg) > MAX_NODES) ? (NODE_W + 1)'(MAX_NODES)
                                                  : (NODE_W + 1)'(edge_count_reg);
    assign no = (32'(otu_count_reg) > MAX_OTUS) ? (OTU_W + 1)'(MAX_OTUS)
                                                : (OTU_W + 1)'(otu_count_reg);

    assign f_len    = node_rdata[LEN_W-1:0];
    assign f_parent = node_rdata[LEN_W +: PARENT_W];
    assign f_edge   = node_rdata[LEN_W + PARENT_W +: IDX_W];

    // weighted walk arithmetic
    assign inc_raw  = prod_reg[PROD_W-1:FRAC_W];
    assign inc32    = inc_raw[LEN_W] ? '1 : inc_raw[LEN_W-1:0];
    assign wt_sum   = {1'b0, w_reg} + {1'b0, inc32};
    assign norm_sum = {1'b0, norm_reg} + (NORM_W + 1)'(inc32);

    // pair arithmetic
    assign abs_diff = (wa_reg > wt_rdata) ? (wa_reg - wt_rdata) : (wt_rdata - wa_reg);
    assign uw_den   = DEN_W'(distinct_reg) + DEN_W'(shared_reg);
    assign nrm_den  = {1'b0, na_reg} + {1'b0, nrm_rdata};

    // walk stops at root, out-of-table parent, or the cycle guard
    assign walk_end = parent_reg[PARENT_W-1]
                   || (32'(parent_reg[PARENT_W-2:0]) >= MAX_NODES)
                   || (32'(steps_reg) + 1 >= MAX_NODES);

    assign div_rem_sh = {div_rem_reg, div_num_reg[QUO_W-1]};
    assign div_ge     = (div_rem_sh >= {1'b0, div_den_reg});
    assign div_diff   = div_rem_sh - {1'b0, div_den_reg};

    // load ops write straight from the input word
    assign node_we    = in_accept && (op == OP_LOAD_NODE) && (32'(node_index) < MAX_NODES);
    assign node_waddr = NODE_W'(node_index);
    assign node_wdata = {edge_index, parent_index, edge_length};
    assign len_we     = in_accept && (op == OP_LOAD_NODE) && (32'(edge_index) < MAX_NODES);
    assign len_waddr  = NODE_W'(edge_index);
    assign cnt_we     = in_accept && (op == OP_LOAD_COUNT) && (32'(node_index) < MAX_OTUS);
    assign cnt_waddr  = OTU_W'(node_index);

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        weighted_next   = weighted_reg;
        normalize_next  = normalize_reg;
        otu_count_next  = otu_count_reg;
        edge_count_next = edge_count_reg;
        samp_a_next     = samp_a_reg;
        samp_b_next     = samp_b_reg;
        e_next          = e_reg;
        o_next          = o_reg;
        depth_next      = depth_reg;
        norm_next       = norm_reg;
        rel_next        = rel_reg;
        node_next       = node_reg;
        steps_next      = steps_reg;
        parent_next     = parent_reg;
        len_next        = len_reg;
        edge_next       = edge_reg;
        w_next          = w_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        distinct_next   = distinct_reg;
        shared_next     = shared_reg;
        wa_next         = wa_reg;
        na_next         = na_reg;
        res_dist_next   = res_dist_reg;
        res_stat_next   = res_stat_reg;
        dist_next       = dist_reg;
        stat_next       = stat_reg;

        div_start  = 1'b0;
        div_num_in = '0;
        div_den_in = '0;

        node_raddr = node_reg;
        len_raddr  = e_reg[NODE_W-1:0];
        cnt_raddr  = o_reg[OTU_W-1:0];
        wt_we      = 1'b0;
        wt_waddr   = {samp_a_reg, edge_reg};
        wt_wdata   = '0;
        wt_raddr   = {samp_a_reg, e_reg[NODE_W-1:0]};
        nrm_we     = 1'b0;
        nrm_waddr  = samp_a_reg;
        nrm_raddr  = samp_a_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WEIGHTED:   weighted_next   = cfg_data[0];
                CFG_NORMALIZE:  normalize_next  = cfg_data[0];
                CFG_OTU_COUNT:  otu_count_next  = cfg_data[OTU_CNT_W-1:0];
                CFG_EDGE_COUNT: edge_count_next = cfg_data[EDGE_CNT_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    samp_a_next   = SAMP_W'(sample_a);
                    samp_b_next   = SAMP_W'(sample_b);
                    e_next        = '0;
                    o_next        = '0;
                    depth_next    = '0;
                    norm_next     = '0;
                    sum_next      = '0;
                    distinct_next = '0;
                    shared_next   = '0;
                    if (op == OP_BUILD && 32'(sample_a) < MAX_SAMPLES)
                    begin
                        state_next = (ne == '0) ? S_DRD : S_CLR;
                    end
                    else if (op == OP_PAIR)
                    begin
                        state_next = (ne == '0) ? S_PFIN : S_PA;
                    end
                end
            end
            S_CLR:
            begin
                wt_we    = 1'b1;
                wt_waddr = {samp_a_reg, e_reg[NODE_W-1:0]};
                e_next   = e_reg + 1'b1;
                if (e_reg + 1'b1 == ne)
                begin
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                if (o_reg == no)
                begin
                    o_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_DACC;
                end
            end
            S_DACC:
            begin
                depth_next = depth_reg + DEPTH_W'(cnt_rdata);
                o_next     = o_reg + 1'b1;
                state_next = S_DRD;
            end
            S_ORD:
            begin
                state_next = (o_reg == no) ? S_BFIN : S_OCHK;
            end
            S_OCHK:
            begin
                if (cnt_rdata == '0)
                begin
                    o_next     = o_reg + 1'b1;
                    state_next = S_ORD;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num_in = QUO_W'({cnt_rdata, {FRAC_W{1'b0}}});
                    div_den_in = DEN_W'(depth_reg);
                    state_next = S_ODIV;
                end
            end
            S_ODIV:
            begin
                if (!div_busy_reg)
                begin
                    rel_next   = div_quo_reg[REL_W-1:0];
                    node_next  = NODE_W'(o_reg);
                    steps_next = '0;
                    if (32'(o_reg) < MAX_NODES)
                    begin
                        state_next = S_WNODE;
                    end
                    else
                    begin
                        o_next     = o_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            S_WNODE:
            begin
                state_next = S_WEDGE;
            end
            S_WEDGE:
            begin
                parent_next = f_parent;
                len_next    = f_len;
                edge_next   = NODE_W'(f_edge);
                wt_raddr    = {samp_a_reg, NODE_W'(f_edge)};
                if ((NODE_W + 1)'(f_edge) >= ne || 32'(f_edge) >= MAX_NODES)
                begin
                    o_next     = o_reg + 1'b1;
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_WWT;
                end
            end
            S_WWT:
            begin
                w_next = wt_rdata;
                if (weighted_reg)
                begin
                    prod_next  = len_reg * rel_reg;
                    state_next = S_WMUL;
                end
                else if (wt_rdata != '0)
                begin
                    // edge already marked: the rest of the path is too
                    o_next     = o_reg + 1'b1;
                    state_next = S_ORD;
                end
                else
                begin
                    wt_we      = 1'b1;
                    wt_wdata   = LEN_W'(1);
                    steps_next = steps_reg + 1'b1;
                    node_next  = NODE_W'(parent_reg);
                    if (walk_end)
                    begin
                        o_next     = o_reg + 1'b1;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        state_next = S_WNODE;
                    end
                end
            end
            S_WMUL:
            begin
                wt_we      = 1'b1;
                wt_wdata   = wt_sum[LEN_W] ? '1 : wt_sum[LEN_W-1:0];
                norm_next  = norm_sum[NORM_W] ? '1 : norm_sum[NORM_W-1:0];
                steps_next = steps_reg + 1'b1;
                node_next  = NODE_W'(parent_reg);
                if (walk_end)
                begin
                    o_next     = o_reg + 1'b1;
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_WNODE;
                end
            end
            S_BFIN:
            begin
                nrm_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_PA:
            begin
                state_next = S_PB;
            end
            S_PB:
            begin
                wa_next    = wt_rdata;
                wt_raddr   = {samp_b_reg, e_reg[NODE_W-1:0]};
                state_next = S_PC;
            end
            S_PC:
            begin
                if (weighted_reg)
                begin
                    sum_next = sum_reg + SUM_W'(abs_diff);
                end
                else if (wa_reg != '0 && wt_rdata != '0)
                begin
                    shared_next = shared_reg + SUM_W'(len_rdata);
                end
                else if (wa_reg != '0 || wt_rdata != '0)
                begin
                    distinct_next = distinct_reg + SUM_W'(len_rdata);
                end
                e_next   = e_reg + 1'b1;
                wt_raddr = {samp_a_reg, NODE_W'(e_reg + 1'b1)};
                state_next = (e_reg + 1'b1 == ne) ? S_PFIN : S_PB;
            end
            S_PFIN:
            begin
                if (weighted_reg)
                begin
                    if (normalize_reg)
                    begin
                        state_next = S_PNA;
                    end
                    else
                    begin
                        res_dist_next = (|sum_reg[SUM_W-1:DIST_W]) ? '1
                                                                   : sum_reg[DIST_W-1:0];
                        res_stat_next = 1'b0;
                        state_next    = S_POUT;
                    end
                end
                else if (uw_den == '0)
                begin
                    res_dist_next = '0;
                    res_stat_next = 1'b1;
                    state_next    = S_POUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num_in = {distinct_reg, {FRAC_W{1'b0}}};
                    div_den_in = uw_den;
                    state_next = S_PDIV;
                end
            end
            S_PNA:
            begin
                state_next = S_PNB;
            end
            S_PNB:
            begin
                na_next    = nrm_rdata;
                nrm_raddr  = samp_b_reg;
                state_next = S_PDEN;
            end
            S_PDEN:
            begin
                if (nrm_den == '0)
                begin
                    res_dist_next = '0;
                    res_stat_next = 1'b1;
                    state_next    = S_POUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num_in = {sum_reg, {FRAC_W{1'b0}}};
                    div_den_in = nrm_den;
                    state_next = S_PDIV;
                end
            end
            S_PDIV:
            begin
                if (!div_busy_reg)
                begin
                    res_dist_next = (|div_quo_reg[QUO_W-1:DIST_W]) ? '1
                                                                   : div_quo_reg[DIST_W-1:0];
                    res_stat_next = 1'b0;
                    state_next    = S_POUT;
                end
            end
            S_POUT:
            begin
                // output slot free or being emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    dist_next      = res_dist_reg;
                    stat_next      = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // one quotient bit per cycle
    always_comb
    begin
        div_busy_next = div_busy_reg;
        div_num_next  = div_num_reg;
        div_den_next  = div_den_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_cnt_next  = div_cnt_reg;
        if (div_start)
        begin
            div_busy_next = 1'b1;
            div_num_next  = div_num_in;
            div_den_next  = div_den_in;
            div_rem_next  = '0;
            div_quo_next  = '0;
            div_cnt_next  = '0;
        end
        else if (div_busy_reg)
        begin
            div_num_next = {div_num_reg[QUO_W-2:0], 1'b0};
            div_rem_next = div_ge ? div_diff[DEN_W-1:0] : div_rem_sh[DEN_W-1:0];
            div_quo_next = {div_quo_reg[QUO_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
            if (div_cnt_reg == DIV_CNT_W'(QUO_W - 1))
            begin
                div_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            div_busy_reg   <= 1'b0;
            weighted_reg   <= 1'b0;
            normalize_reg  <= 1'b0;
            otu_count_reg  <= OTU_COUNT_RST;
            edge_count_reg <= EDGE_COUNT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            div_busy_reg   <= div_busy_next;
            weighted_reg   <= weighted_next;
            normalize_reg  <= normalize_next;
            otu_count_reg  <= otu_count_next;
            edge_count_reg <= edge_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_a_reg   <= samp_a_next;
        samp_b_reg   <= samp_b_next;
        e_reg        <= e_next;
        o_reg        <= o_next;
        depth_reg    <= depth_next;
        norm_reg     <= norm_next;
        rel_reg      <= rel_next;
        node_reg     <= node_next;
        steps_reg    <= steps_next;
        parent_reg   <= parent_next;
        len_reg      <= len_next;
        edge_reg     <= edge_next;
        w_reg        <= w_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        distinct_reg <= distinct_next;
        shared_reg   <= shared_next;
        wa_reg       <= wa_next;
        na_reg       <= na_next;
        res_dist_reg <= res_dist_next;
        res_stat_reg <= res_stat_next;
        dist_reg     <= dist_next;
        stat_reg     <= stat_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_cnt_reg  <= div_cnt_next;
    end

    ufde_ram #(.WIDTH(NODE_ENT_W), .DEPTH(MAX_NODES)) u_node_mem (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    ufde_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES)) u_len_mem (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (edge_length),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    ufde_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_OTUS)) u_cnt_mem (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (count),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    ufde_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SAMPLES * MAX_NODES)) u_wt_mem (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    ufde_ram #(.WIDTH(NORM_W), .DEPTH(MAX_SAMPLES)) u_nrm_mem (
        .clk   (clk),
        .we    (nrm_we),
        .waddr (nrm_waddr),
        .wdata (norm_reg),
        .raddr (nrm_raddr),
        .rdata (nrm_rdata)
    );

endmodule

### hw/rtl/ufde_checker.sv
// Port-level checker for the UniFrac distance engine, bound to the top level.
// Uses ufde_pkg and unifrac_distance_engine_unit_macros.svh.
`include "unifrac_distance_engine_unit_macros.svh"

module ufde_checker
    import ufde_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [OP_W-1:0]    op,
    input logic               out_valid,
    input logic               out_stall,
    input logic [DIST_W-1:0]  distance,
    input logic               status
);

    // a held result word stays put
    `UFDE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance) && $stable(status), "stalled result word changed")

    // zero denominator forces a zero distance
    `UFDE_ASSERT_SAME(a_status_zero, out_valid && status, distance == '0, "error status with nonzero distance")

    // loads never block the next word
    `UFDE_ASSERT_NEXT(a_load_ready, in_valid && !in_stall && (op == OP_LOAD_NODE || op == OP_LOAD_COUNT), !in_stall, "stall after a load word")

    // a pair op occupies the engine
    `UFDE_ASSERT_NEXT(a_pair_busy, in_valid && !in_stall && op == OP_PAIR, in_stall, "no stall after a pair word")

endmodule

bind unifrac_distance_engine_unit ufde_checker u_checker (.*);

### dv/unifrac_distance_engine_unit_tb.sv
// Self-checking testbench for the UniFrac distance engine top level.
// Depends on ufde_pkg and unifrac_distance_engine_unit; nothing else.
module unifrac_distance_engine_unit_tb;
    import ufde_pkg::*;

    localparam int LIMIT_CYCLES = 100_000_000;
    localparam int LONG_HOLD    = 2500;
    localparam int TIPS         = 64;
    localparam int INNER_LO     = 512;
    localparam int INNER_HI     = 532;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [47:0] NORM_SAT = 48'hFFFF_FFFF_FFFF;

    // one op word as seen on the input channel
    typedef struct {
        op_t                        op;
        logic [IDX_W-1:0]           node;
        logic [IDX_W-1:0]           edge_i;
        logic signed [PARENT_W-1:0] parent;
        logic [LEN_W-1:0]           len;
        logic [COUNT_W-1:0]         cnt;
        logic [SAMPLE_W-1:0]        sa;
        logic [SAMPLE_W-1:0]        sb;
    } op_word_t;

    typedef struct {
        logic [DIST_W-1:0] dist_v;
        logic              stat;
    } dist_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [OP_W-1:0]            op = '0;
    logic [IDX_W-1:0]           node_index = '0;
    logic [IDX_W-1:0]           edge_index = '0;
    logic signed [PARENT_W-1:0] parent_index = '0;
    logic [LEN_W-1:0]           edge_length = '0;
    logic [COUNT_W-1:0]         count = '0;
    logic [SAMPLE_W-1:0]        sample_a = '0;
    logic [SAMPLE_W-1:0]        sample_b = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [DIST_W-1:0]          distance;
    logic                       status;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    unifrac_distance_engine_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .node_index   (node_index),
        .edge_index   (edge_index),
        .parent_index (parent_index),
        .edge_length  (edge_length),
        .count        (count),
        .sample_a     (sample_a),
        .sample_b     (sample_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance     (distance),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the engine: tree, counts, weight rows, norms, registers.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]           tree_edge   [MAX_NODES];
    logic signed [PARENT_W-1:0] tree_parent [MAX_NODES];
    logic [LEN_W-1:0]           tree_len    [MAX_NODES];
    logic [LEN_W-1:0]           len_by_edge [MAX_NODES];
    logic [COUNT_W-1:0]         otu_abund   [MAX_OTUS];
    logic [31:0]                wrow        [MAX_SAMPLES][MAX_NODES];
    logic [NORM_W-1:0]          row_norm    [MAX_SAMPLES];

    logic                   sh_weighted  = 1'b0;
    logic                   sh_normalize = 1'b0;
    logic [OTU_CNT_W-1:0]   sh_otus      = OTU_COUNT_RST;
    logic [EDGE_CNT_W-1:0]  sh_edges     = EDGE_COUNT_RST;

    op_word_t   word_q [$];      // words waiting for the driver
    dist_word_t dist_expect [$]; // distances still owed by the engine

    int  pushed_n   = 0;
    int  accepted_n = 0;
    int  err_n      = 0;
    int  cycle_n    = 0;

    // idling control
    int  gap_left   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    logic quiet     = 1'b0;
    logic hold_go   = 1'b0;
    logic hold_taken = 1'b0;

    // generation-side view of which rows may be read safely
    int  row_ext [MAX_SAMPLES];
    bit  row_built [MAX_SAMPLES];

    function automatic int used_edges();
        return (sh_edges > MAX_NODES) ? MAX_NODES : int'(sh_edges);
    endfunction

    function automatic int used_otus();
        return (sh_otus > MAX_OTUS) ? MAX_OTUS : int'(sh_otus);
    endfunction

    // Clear the row, sum the depth, then walk each nonzero tip to the root.
    function automatic void build_weights(int s);
        int ne;
        int no;
        int nd;
        int steps;
        int e;
        logic [63:0] depth;
        logic [63:0] c;
        logic [63:0] rel;
        logic [63:0] inc;
        logic [63:0] w;
        logic [63:0] nrm;
        ne = used_edges();
        no = used_otus();
        for (int i = 0; i < ne; i++) wrow[s][i] = '0;
        row_norm[s] = '0;
        depth = '0;
        for (int o = 0; o < no; o++) depth += 64'(otu_abund[o]);
        for (int o = 0; o < no; o++)
        begin
            c = 64'(otu_abund[o]);
            if (c == 0) continue;
            rel = (depth != 0) ? (c << 16) / depth : 64'd0;
            nd = o;
            steps = 0;
            while (nd >= 0 && nd < MAX_NODES && steps < MAX_NODES)
            begin
                e = int'(tree_edge[nd]);
                if (e >= ne) break;
                if (sh_weighted)
                begin
                    inc = (64'(tree_len[nd]) * rel) >> 16;
                    if (inc > 64'hFFFF_FFFF) inc = 64'hFFFF_FFFF;
                    w = 64'(wrow[s][e]) + inc;
                    wrow[s][e] = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
                    nrm = 64'(row_norm[s]) + inc;
                    row_norm[s] = (nrm > 64'(NORM_SAT)) ? NORM_SAT : nrm[47:0];
                end
                else
                begin
                    if (wrow[s][e] != 0) break;
                    wrow[s][e] = 32'd1;
                end
                nd = int'(tree_parent[nd]);
                steps++;
            end
        end
    endfunction

    function automatic dist_word_t pair_dist(int a, int b);
        dist_word_t r;
        int ne;
        logic [63:0] sum;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] distinct;
        logic [63:0] shared;
        logic [31:0] wa;
        logic [31:0] wb;
        ne = used_edges();
        q = '0;
        r.stat = 1'b0;
        if (sh_weighted)
        begin
            sum = '0;
            for (int e = 0; e < ne; e++)
            begin
                wa = wrow[a][e];
                wb = wrow[b][e];
                sum += (wa > wb) ? 64'(wa - wb) : 64'(wb - wa);
            end
            if (sh_normalize)
            begin
                den = 64'(row_norm[a]) + 64'(row_norm[b]);
                if (den == 0) r.stat = 1'b1;
                else q = (sum << 16) / den;
            end
            else
                q = sum;
        end
        else
        begin
            distinct = '0;
            shared = '0;
            for (int e = 0; e < ne; e++)
            begin
                if (wrow[a][e] != 0 && wrow[b][e] != 0) shared += 64'(len_by_edge[e]);
                else if (wrow[a][e] != 0 || wrow[b][e] != 0)
                    distinct += 64'(len_by_edge[e]);
            end
            if (distinct + shared == 0) r.stat = 1'b1;
            else q = (distinct << 16) / (distinct + shared);
        end
        r.dist_v = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        return r;
    endfunction

    // Apply one accepted word to the shadow; pairs leave an expectation.
    function automatic void engine_step(op_word_t w);
        case (w.op)
            OP_LOAD_NODE:
            begin
                tree_edge[w.node]   = w.edge_i;
                tree_parent[w.node] = w.parent;
                tree_len[w.node]    = w.len;
                len_by_edge[w.edge_i] = w.len;
            end
            OP_LOAD_COUNT:
                if (w.node < MAX_OTUS) otu_abund[w.node] = w.cnt;
            OP_BUILD:
                build_weights(int'(w.sa));
            default:
                dist_expect.push_back(pair_dist(int'(w.sa), int'(w.sb)));
        endcase
    endfunction

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
        $display("[%0d] %s: expected %0h, got %0h", cycle_n, what, exp_v, got_v);
        err_n++;
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: one word per handshake, random gap bursts between words.
    // Valid is decided only when nothing is being held on the bus.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        op_word_t w;
        logic     free;
        if (rst_n)
        begin
            free = !in_valid;
            if (in_valid && !in_stall)
            begin
                w.op = op_t'(op);
                w.node = node_index;
                w.edge_i = edge_index;
                w.parent = parent_index;
                w.len = edge_length;
                w.cnt = count;
                w.sa = sample_a;
                w.sb = sample_b;
                engine_step(w);
                accepted_n <= accepted_n + 1;
                free = 1'b1;
            end
            if (free)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= $urandom_range(0, 15);
                end
                else if (word_q.size() > 0)
                begin
                    w = word_q.pop_front();
                    in_valid     <= 1'b1;
                    op           <= w.op;
                    node_index   <= w.node;
                    edge_index   <= w.edge_i;
                    parent_index <= w.parent;
                    edge_length  <= w.len;
                    count        <= w.cnt;
                    sample_a     <= w.sa;
                    sample_b     <= w.sb;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold, counted here once requested.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_go && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left  <= LONG_HOLD;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stall bursts, the long hold, and the
    // field-by-field check against the oldest expected distance.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dist_word_t x;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (dist_expect.size() == 0)
                    report("unexpected result word", 64'd0, 64'(distance));
                else
                begin
                    x = dist_expect.pop_front();
                    if (distance !== x.dist_v)
                        report("distance", 64'(x.dist_v), 64'(distance));
                    if (status !== x.stat) report("status", 64'(x.stat), 64'(status));
                end
            end
            if ((hold_go && !hold_taken) || hold_left > 0)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 15);
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic op_word_t rand_word(op_t o);
        op_word_t w;
        w.op = o;
        w.node = IDX_W'($urandom());
        w.edge_i = IDX_W'($urandom());
        w.parent = PARENT_W'($urandom());
        w.len = $urandom();
        w.cnt = COUNT_W'($urandom());
        w.sa = SAMPLE_W'($urandom());
        w.sb = SAMPLE_W'($urandom());
        return w;
    endfunction

    // Shallow tree: tips hang off 16 inner nodes, then 4, then one root.
    function automatic logic signed [PARENT_W-1:0] home_parent(int i);
        if (i < 512) return PARENT_W'(512 + i % 16);
        if (i < 528) return PARENT_W'(528 + i % 4);
        if (i < 532) return PARENT_W'(532);
        return -PARENT_W'(1);
    endfunction

    // Parent for a rewired node: a root mark or a node loaded at start.
    function automatic logic signed [PARENT_W-1:0] any_parent();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0) return -PARENT_W'(1);
        if (k == 1) return -PARENT_W'($urandom_range(2, 1024));
        if (k == 2) return PARENT_W'($urandom_range(0, TIPS - 1));
        return PARENT_W'($urandom_range(INNER_LO, INNER_HI));
    endfunction

    task automatic push_word(op_word_t w);
        if (w.op == OP_BUILD)
        begin
            row_built[w.sa] = 1'b1;
            if (row_ext[w.sa] < used_edges()) row_ext[w.sa] = used_edges();
        end
        word_q.push_back(w);
        pushed_n++;
    endtask

    task automatic node_word(int i, logic [LEN_W-1:0] len);
        op_word_t w;
        w = rand_word(OP_LOAD_NODE);
        w.node = IDX_W'(i);
        w.edge_i = IDX_W'(i);
        w.parent = home_parent(i);
        w.len = len;
        push_word(w);
    endtask

    task automatic count_word(int i, logic [COUNT_W-1:0] c);
        op_word_t w;
        w = rand_word(OP_LOAD_COUNT);
        w.node = IDX_W'(i);
        w.cnt = c;
        push_word(w);
    endtask

    task automatic build_word(int s);
        op_word_t w;
        w = rand_word(OP_BUILD);
        w.sa = SAMPLE_W'(s);
        push_word(w);
    endtask

    function automatic bit row_readable(int s);
        return row_built[s] && row_ext[s] >= used_edges();
    endfunction

    task automatic pair_word(int a, int b);
        op_word_t w;
        w = rand_word(OP_PAIR);
        w.sa = SAMPLE_W'(a);
        w.sb = SAMPLE_W'(b);
        push_word(w);
    endtask

    // Pair on two readable rows; builds a row first when none is readable.
    task automatic rand_pair();
        int ok [$];
        for (int s = 0; s < MAX_SAMPLES; s++)
            if (row_readable(s)) ok.push_back(s);
        if (ok.size() == 0)
        begin
            build_word($urandom_range(0, 7));
            rand_pair();
        end
        else
            pair_word(ok[$urandom_range(0, ok.size() - 1)],
                      ok[$urandom_range(0, ok.size() - 1)]);
    endtask

    task automatic rand_item();
        op_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if ($urandom_range(0, 9) < 8)
                node_word($urandom_range(0, MAX_NODES - 1), $urandom());
            else
            begin
                // rewired node: any edge, parent is a root mark or a loaded node
                w = rand_word(OP_LOAD_NODE);
                w.parent = any_parent();
                push_word(w);
            end
        end
        else if (pick < 50)
        begin
            w = rand_word(OP_LOAD_COUNT);
            if ($urandom_range(0, 3) == 0) w.cnt = '0;
            else if ($urandom_range(0, 3) != 0) w.cnt = COUNT_W'($urandom_range(0, 4000));
            if ($urandom_range(0, 3) != 0) w.node = IDX_W'($urandom_range(0, 31));
            push_word(w);
        end
        else if (pick < 72)
            build_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 7));
        else
            rand_pair();
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WEIGHTED:   sh_weighted  = val[0];
            CFG_NORMALIZE:  sh_normalize = val[0];
            CFG_OTU_COUNT:  sh_otus      = val[OTU_CNT_W-1:0];
            CFG_EDGE_COUNT: sh_edges     = val[EDGE_CNT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Sender holds back until every word went in and every distance came out.
    task automatic drain();
        do @(posedge clk);
        while (accepted_n != pushed_n || dist_expect.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int n_items;
        for (int s = 0; s < MAX_SAMPLES; s++)
        begin
            row_ext[s] = 0;
            row_built[s] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Keep the tip set small so every node and count a build reads is loaded.
        cfg_write(CFG_OTU_COUNT, CFG_DATA_W'(TIPS));
        for (int i = 0; i < TIPS; i++)
            node_word(i, $urandom_range(1, 32'h0004_0000));
        for (int i = INNER_LO; i <= INNER_HI; i++)
            node_word(i, $urandom_range(1, 32'h0004_0000));
        for (int i = 0; i < TIPS; i++)
            count_word(i, ($urandom_range(0, 3) == 0) ? 24'd0
                                                      : COUNT_W'($urandom_range(1, 500)));

        // Directed corners: extreme lengths and counts, ignored OTU index,
        // root parent, most negative parent (walk stops), then builds/pairs.
        node_word(7, 32'hFFFF_FFFF);
        node_word(8, 32'd0);
        node_word(1023, 32'hFFFF_FFFF);
        count_word(7, 24'hFF_FFFF);
        count_word(1, 24'd1);
        count_word(MAX_OTUS + 3, 24'hAB_CDEF);
        count_word(1023, 24'h12_3456);
        begin
            op_word_t w;
            w = rand_word(OP_LOAD_NODE);
            w.node = 10'd3;
            w.edge_i = 10'd3;
            w.parent = -PARENT_W'(1024);
            push_word(w);
            w.node = 10'd530;
            w.edge_i = 10'd530;
            w.parent = -PARENT_W'(1);
            w.len = $urandom();
            push_word(w);
        end
        build_word(0);
        build_word(63);
        pair_word(0, 63);
        pair_word(63, 63);
        drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0: ; // unweighted, full tip set, all edges
                1:
                begin
                    cfg_write(CFG_WEIGHTED, 11'd1);
                    cfg_write(CFG_NORMALIZE, 11'd0);
                    cfg_write(CFG_OTU_COUNT, 11'd16);
                end
                2: cfg_write(CFG_NORMALIZE, 11'd1);
                3:
                begin
                    cfg_write(CFG_WEIGHTED, 11'd0);
                    cfg_write(CFG_OTU_COUNT, 11'd1);
                    cfg_write(CFG_EDGE_COUNT, 11'd1);
                end
                4:
                begin
                    // edge count past the limit clamps; unknown index is dropped
                    cfg_write(CFG_WEIGHTED, 11'd1);
                    cfg_write(CFG_OTU_COUNT, CFG_DATA_W'(TIPS));
                    cfg_write(CFG_EDGE_COUNT, 11'd2047);
                    cfg_write(CFG_UNUSED, 11'd0);
                end
                5:
                begin
                    // no edges and no tips: zero denominators
                    cfg_write(CFG_OTU_COUNT, 11'd0);
                    cfg_write(CFG_EDGE_COUNT, 11'd0);
                end
                6:
                begin
                    cfg_write(CFG_WEIGHTED, 11'd0);
                    cfg_write(CFG_EDGE_COUNT, 11'd0);
                end
                default:
                begin
                    cfg_write(CFG_WEIGHTED, CFG_DATA_W'($urandom_range(0, 1)));
                    cfg_write(CFG_NORMALIZE, CFG_DATA_W'($urandom_range(0, 1)));
                    cfg_write(CFG_OTU_COUNT, CFG_DATA_W'($urandom_range(1, 24)));
                    cfg_write(CFG_EDGE_COUNT, ($urandom_range(0, 2) == 0)
                                              ? CFG_DATA_W'($urandom_range(1, 1024))
                                              : 11'd1024);
                end
            endcase
            if (ph == 8) hold_go <= 1'b1;
            if (ph >= 12) quiet <= 1'b1;
            n_items = 28;
            for (int k = 0; k < n_items; k++) rand_item();
            // close with a pair so its result proves the engine is idle
            build_word($urandom_range(0, 7));
            rand_pair();
            drain();
        end

        if (err_n == 0 && dist_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ufde_pkg.sv
hw/rtl/ufde_ram.sv
hw/rtl/unifrac_distance_engine_unit.sv
hw/rtl/ufde_checker.sv
dv/unifrac_distance_engine_unit_tb.sv
